FILE: hw/rtl/coo_to_csr_converter_assert.svh
// Assertion macros shared by the converter's checker.
`ifndef COO_TO_CSR_CONVERTER_ASSERT_SVH
`define COO_TO_CSR_CONVERTER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define C2C_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define C2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/c2c_pkg.sv
// Shared constants and request/response layouts of the COO to CSR converter.
package c2c_pkg;

   localparam int C2C_ROWS    = 1024;
   localparam int C2C_ENTRIES = 4096;
   localparam int C2C_VALUE_W = 32;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;

   // function codes (req_tuser)
   localparam logic [FUNC_W-1:0] FN_LOAD       = 2'd0;
   localparam logic [FUNC_W-1:0] FN_READ_PTR   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ_ENTRY = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADREAD  = 2'd3;

   // req_tdata, lowest bits last in the list
   typedef struct packed {
      logic [4:0]             pad;
      logic [12:0]            read_index;
      logic [C2C_VALUE_W-1:0] entry_value;
      logic [10:0]            column_number;
      logic [10:0]            row_number;
   } req_type;

   // rsp_tdata, lowest bits last in the list
   typedef struct packed {
      logic [1:0]             pad;
      logic [STATUS_W-1:0]    status;
      logic [C2C_VALUE_W-1:0] out_value;
      logic [9:0]             out_column;
      logic [12:0]            row_start;
      logic [12:0]            entry_total;
   } rsp_type;

endpackage

FILE: hw/rtl/coo_to_csr_converter.sv
// Top level of the COO to CSR sparse matrix converter.
//
// Load requests (req_tuser = load) carry one-based (row, column, value) entries. Each
// stored entry goes into a staging RAM in arrival order and is counted into a per-row
// histogram held in the row RAM (read-modify-write with forwarding), so loads stream
// at one per cycle while the response port is not stalled. A load with req_tlast set
// ends the matrix: its response (entry count and status) is sent at once, then the
// block runs the conversion while req_tready is low: a settle state, a prefix sum that
// turns the histogram into per-row write cursors, then a scatter of each stored entry's
// column and value into the CSR RAM, arrival order kept within a row. After the scatter
// the row RAM holds row_pointers[r+1] for each row r, which is what a pointer read
// returns (index 0 answers 0 without a RAM access). Pointer and entry reads each go
// through one RAM read; a rejected read answers without one. A load that follows a
// finished conversion starts a new matrix: it waits while the row RAM is cleared, the
// same pass that runs after reset. Dropped loads (bad coordinate, full staging RAM)
// answer with status; stored non-final loads give no response.
module coo_to_csr_converter
   import c2c_pkg::*;
#(
   parameter int ROWS    = C2C_ROWS,
   parameter int ENTRIES = C2C_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row_number[10:0], column_number[21:11], entry_value[53:22], read_index[66:54], 0
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  logic [FUNC_W-1:0]     req_tuser,
   // final_entry
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entry_total[12:0], row_start[25:13], out_column[35:26], out_value[67:36],
   // status[69:68], 0
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ROW_W = $clog2(ROWS);
   localparam int ENT_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int STG_W = 2 * ROW_W + C2C_VALUE_W;
   localparam int CSR_W = ROW_W + C2C_VALUE_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_PREFIX,
      S_SCATTER
   } state_type;

   state_type state_ff, state_in;

   // control
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             conv_ff, conv_in;
   logic             ovf_ff, ovf_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic             pf_issue_ff, pf_issue_in;
   logic             pf_v_ff, pf_v_in;
   logic [ROW_W-1:0] pf_addr_ff, pf_addr_in;
   logic [CNT_W-1:0] sc_addr_ff, sc_addr_in;
   logic             b_v_ff, b_v_in;
   logic             rmw_v_ff, rmw_v_in;
   logic             rmw_scat_ff, rmw_scat_in;
   logic             fwd_v_ff, fwd_v_in;

   // payload
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [ROW_W-1:0]       pf_wa_ff, pf_wa_in;
   logic [CNT_W-1:0]       sum_ff, sum_in;
   logic [ROW_W-1:0]       rmw_row_ff, rmw_row_in;
   logic [ROW_W-1:0]       rmw_col_ff, rmw_col_in;
   logic [C2C_VALUE_W-1:0] rmw_val_ff, rmw_val_in;
   logic [ROW_W-1:0]       fwd_row_ff, fwd_row_in;
   logic [CNT_W-1:0]       fwd_data_ff, fwd_data_in;

   // RAM ports
   logic             rm_we;
   logic [ROW_W-1:0] rm_wa, rm_ra;
   logic [CNT_W-1:0] rm_wd, rm_q;
   logic             stg_we;
   logic [STG_W-1:0] stg_wd, stg_q;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wd, csr_q;

   // request decode
   req_type             req;
   logic                is_load, row_ok, col_ok, full, out_free, acc, load_store;
   logic [ROW_W-1:0]    row0, col0;
   logic                ptr_ok, ent_ok, imm_v, rd_issue;
   logic [STATUS_W-1:0] load_code;
   rsp_type             imm_rsp;
   logic [CNT_W-1:0]    cnt_next;

   // read-modify-write on the row RAM (histogram and scatter cursors)
   logic [CNT_W-1:0] rmw_eff, rmw_next;
   logic [ROW_W-1:0] stg_row, stg_col;
   logic [C2C_VALUE_W-1:0] stg_val;
   logic sc_issue;

   assign req        = req_type'(req_tdata);
   assign is_load    = (req_tuser == FN_LOAD);
   assign row_ok     = (req.row_number != '0) && (32'(req.row_number) <= 32'(ROWS));
   assign col_ok     = (req.column_number != '0) && (32'(req.column_number) <= 32'(ROWS));
   assign full       = (32'(cnt_ff) >= 32'(ENTRIES));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free && !(is_load && conv_ff);
   assign acc        = req_tvalid && req_tready;
   assign load_store = acc && is_load && row_ok && col_ok && !full;
   assign row0       = ROW_W'(req.row_number - 11'd1);
   assign col0       = ROW_W'(req.column_number - 11'd1);
   assign ptr_ok     = conv_ff && (32'(req.read_index) <= 32'(ROWS));
   assign ent_ok     = conv_ff && (32'(req.read_index) < 32'(cnt_ff));
   assign cnt_next   = cnt_ff + CNT_W'(load_store);

   assign rmw_eff  = (fwd_v_ff && (fwd_row_ff == rmw_row_ff)) ? fwd_data_ff : rm_q;
   assign rmw_next = rmw_eff + CNT_W'(1);

   assign stg_row = stg_q[ROW_W-1:0];
   assign stg_col = stg_q[2*ROW_W-1:ROW_W];
   assign stg_val = stg_q[2*ROW_W +: C2C_VALUE_W];

   assign sc_issue = (sc_addr_ff < cnt_ff);

   // response that is known at acceptance
   always_comb begin
      imm_rsp   = '0;
      imm_v     = 1'b0;
      rd_issue  = 1'b0;
      load_code = ST_OK;
      unique case (req_tuser)
         FN_LOAD: begin
            if (!(row_ok && col_ok)) begin
               load_code = ST_RANGE;
            end else if (full) begin
               load_code = ST_OVERFLOW;
            end
            if (req_tlast) begin
               imm_v               = 1'b1;
               imm_rsp.entry_total = 13'(cnt_next);
               imm_rsp.status      = (load_code == ST_OK && ovf_ff) ? ST_OVERFLOW : load_code;
            end else if (load_code != ST_OK) begin
               imm_v          = 1'b1;
               imm_rsp.status = load_code;
            end
         end
         FN_READ_PTR: begin
            if (!ptr_ok) begin
               imm_v          = 1'b1;
               imm_rsp.status = ST_BADREAD;
            end else if (req.read_index == '0) begin
               imm_v = 1'b1;
            end else begin
               rd_issue = 1'b1;
            end
         end
         FN_READ_ENTRY: begin
            if (!ent_ok) begin
               imm_v          = 1'b1;
               imm_rsp.status = ST_BADREAD;
            end else begin
               rd_issue = 1'b1;
            end
         end
         default: begin
            imm_v          = 1'b1;
            imm_rsp.status = ST_BADREAD;
         end
      endcase
   end

   // row RAM port selection
   always_comb begin
      rm_we = 1'b0;
      rm_wa = rmw_row_ff;
      rm_wd = rmw_next;
      rm_ra = row0;
      unique case (state_ff)
         S_CLEAR: begin
            rm_we = 1'b1;
            rm_wa = clr_ff;
            rm_wd = '0;
         end
         S_IDLE: begin
            rm_we = rmw_v_ff;
            if (req_tuser == FN_READ_PTR) begin
               rm_ra = ROW_W'(req.read_index - 13'd1);
            end
         end
         S_DRAIN: begin
            rm_we = rmw_v_ff;
         end
         S_PREFIX: begin
            rm_ra = pf_addr_ff;
            rm_we = pf_v_ff;
            rm_wa = pf_wa_ff;
            rm_wd = sum_ff;
         end
         S_SCATTER: begin
            rm_ra = stg_row;
            rm_we = rmw_v_ff;
         end
         S_READ: begin
            rm_we = 1'b0;
         end
         default: begin
            rm_we = 1'b0;
         end
      endcase
   end

   assign stg_we = load_store;
   assign stg_wd = {req.entry_value, col0, row0};
   assign csr_we = rmw_v_ff && rmw_scat_ff;
   assign csr_wd = {rmw_val_ff, rmw_col_ff};

   // next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cnt_in       = cnt_ff;
      conv_in      = conv_ff;
      ovf_in       = ovf_ff;
      clr_in       = clr_ff;
      pf_issue_in  = pf_issue_ff;
      pf_v_in      = 1'b0;
      pf_addr_in   = pf_addr_ff;
      pf_wa_in     = pf_wa_ff;
      sum_in       = sum_ff;
      sc_addr_in   = sc_addr_ff;
      b_v_in       = 1'b0;
      rd_ptr_in    = rd_ptr_ff;
      rmw_v_in     = 1'b0;
      rmw_scat_in  = 1'b0;
      rmw_row_in   = rmw_row_ff;
      rmw_col_in   = rmw_col_ff;
      rmw_val_in   = rmw_val_ff;
      fwd_v_in     = rmw_v_ff;
      fwd_row_in   = rmw_row_ff;
      fwd_data_in  = rmw_next;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ROW_W'(1);
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && is_load && conv_ff) begin
               // new matrix: wipe the histogram before taking the load
               state_in = S_CLEAR;
               clr_in   = '0;
               cnt_in   = '0;
               conv_in  = 1'b0;
               ovf_in   = 1'b0;
            end
            if (acc) begin
               if (imm_v) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = imm_rsp;
               end
               if (load_store) begin
                  cnt_in     = cnt_next;
                  rmw_v_in   = 1'b1;
                  rmw_row_in = row0;
               end
               if (is_load && row_ok && col_ok && full) begin
                  ovf_in = 1'b1;
               end
               if (is_load && req_tlast) begin
                  state_in = S_DRAIN;
               end
               if (rd_issue) begin
                  state_in  = S_READ;
                  rd_ptr_in = (req_tuser == FN_READ_PTR);
               end
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            if (rd_ptr_ff) begin
               rsp_data_in.row_start = 13'(rm_q);
            end else begin
               rsp_data_in.out_column = 10'(csr_q[ROW_W-1:0]);
               rsp_data_in.out_value  = csr_q[ROW_W +: C2C_VALUE_W];
            end
            state_in = S_IDLE;
         end
         S_DRAIN: begin
            state_in    = S_PREFIX;
            pf_issue_in = 1'b1;
            pf_addr_in  = '0;
            sum_in      = '0;
         end
         S_PREFIX: begin
            pf_v_in  = pf_issue_ff;
            pf_wa_in = pf_addr_ff;
            if (pf_issue_ff) begin
               if (pf_addr_ff == ROW_W'(ROWS - 1)) begin
                  pf_issue_in = 1'b0;
               end else begin
                  pf_addr_in = pf_addr_ff + ROW_W'(1);
               end
            end
            if (pf_v_ff) begin
               sum_in = sum_ff + rm_q;
            end
            if (!pf_issue_ff && !pf_v_ff) begin
               state_in   = S_SCATTER;
               sc_addr_in = '0;
            end
         end
         S_SCATTER: begin
            b_v_in = sc_issue;
            if (sc_issue) begin
               sc_addr_in = sc_addr_ff + CNT_W'(1);
            end
            if (b_v_ff) begin
               rmw_v_in    = 1'b1;
               rmw_scat_in = 1'b1;
               rmw_row_in  = stg_row;
               rmw_col_in  = stg_col;
               rmw_val_in  = stg_val;
            end
            if (!sc_issue && !b_v_ff && !rmw_v_ff) begin
               conv_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // payload registers carry no reset; control registers do
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rd_ptr_ff   <= rd_ptr_in;
      pf_wa_ff    <= pf_wa_in;
      sum_ff      <= sum_in;
      rmw_row_ff  <= rmw_row_in;
      rmw_col_ff  <= rmw_col_in;
      rmw_val_ff  <= rmw_val_in;
      fwd_row_ff  <= fwd_row_in;
      fwd_data_ff <= fwd_data_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         conv_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         clr_ff       <= '0;
         pf_issue_ff  <= 1'b0;
         pf_v_ff      <= 1'b0;
         pf_addr_ff   <= '0;
         sc_addr_ff   <= '0;
         b_v_ff       <= 1'b0;
         rmw_v_ff     <= 1'b0;
         rmw_scat_ff  <= 1'b0;
         fwd_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         conv_ff      <= conv_in;
         ovf_ff       <= ovf_in;
         clr_ff       <= clr_in;
         pf_issue_ff  <= pf_issue_in;
         pf_v_ff      <= pf_v_in;
         pf_addr_ff   <= pf_addr_in;
         sc_addr_ff   <= sc_addr_in;
         b_v_ff       <= b_v_in;
         rmw_v_ff     <= rmw_v_in;
         rmw_scat_ff  <= rmw_scat_in;
         fwd_v_ff     <= fwd_v_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // histogram, then write cursors, finally row_pointers[r+1]
   c2c_ram #(.WIDTH(CNT_W), .DEPTH(ROWS)) u_row_ram (
      .clock (clock),
      .we    (rm_we),
      .waddr (rm_wa),
      .wdata (rm_wd),
      .raddr (rm_ra),
      .rdata (rm_q)
   );

   // loaded entries in arrival order
   c2c_ram #(.WIDTH(STG_W), .DEPTH(ENTRIES)) u_stage_ram (
      .clock (clock),
      .we    (stg_we),
      .waddr (ENT_W'(cnt_ff)),
      .wdata (stg_wd),
      .raddr (ENT_W'(sc_addr_ff)),
      .rdata (stg_q)
   );

   // converted entries in CSR order
   c2c_ram #(.WIDTH(CSR_W), .DEPTH(ENTRIES)) u_csr_ram (
      .clock (clock),
      .we    (csr_we),
      .waddr (ENT_W'(rmw_eff)),
      .wdata (csr_wd),
      .raddr (ENT_W'(req.read_index)),
      .rdata (csr_q)
   );

endmodule

FILE: hw/rtl/c2c_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module c2c_ram
   import c2c_pkg::*;
#(
   parameter int WIDTH = C2C_VALUE_W,
   parameter int DEPTH = C2C_ENTRIES,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old data on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hw/rtl/c2c_checker.sv
// Port-level checker for the converter, bound to the top level.
`include "coo_to_csr_converter_assert.svh"

module c2c_checker
   import c2c_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [FUNC_W-1:0]     req_tuser,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type rsp;
   logic    acc, acc_final, acc_bad_func;

   assign rsp          = rsp_type'(rsp_tdata);
   assign acc          = req_tvalid && req_tready;
   assign acc_final    = acc && req_tlast && (req_tuser == FN_LOAD);
   assign acc_bad_func = acc && (req_tuser != FN_LOAD) && (req_tuser != FN_READ_PTR) &&
                         (req_tuser != FN_READ_ENTRY);

   // stalled response holds
   `C2C_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // a rejected read carries nothing but its status
   `C2C_ASSERT_IMPLY(a_badread_clean, clock, reset, rsp_tvalid && (rsp.status == ST_BADREAD), (rsp.entry_total == '0) && (rsp.row_start == '0) && (rsp.out_column == '0) && (rsp.out_value == '0), "bad-read response has data")

   // an unknown function answers on the next cycle
   `C2C_ASSERT_NEXT(a_bad_func_rsp, clock, reset, acc_bad_func, rsp_tvalid && (rsp.status == ST_BADREAD), "unknown function not answered")

   // the final load starts the conversion, so no request is taken right after it
   `C2C_ASSERT_NEXT(a_final_blocks, clock, reset, acc_final, !req_tready, "request taken during conversion")

endmodule

bind coo_to_csr_converter c2c_checker u_c2c_checker (.*);

FILE: tb/coo_to_csr_converter_test.sv
// Self-checking stream testbench for the COO to CSR sparse matrix converter.
module coo_to_csr_converter_test;
   import c2c_pkg::*;

   // func code 3 is unused by the block and must answer as a bad read
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
   localparam int ROW_MAX  = C2C_ROWS;
   localparam int FILL_MAX = C2C_ENTRIES;
   // longest walk after a final load: settle, prefix sum, scatter of a full RAM,
   // plus the clearing pass, with margin
   localparam int DRAIN_CYCLES = 8000;

   // one request as the sender sees it, unpacked
   typedef struct {
      logic [FUNC_W-1:0]      func;
      logic [10:0]            row;
      logic [10:0]            col;
      logic [C2C_VALUE_W-1:0] val;
      logic                   fin;
      logic [12:0]            idx;
   } c2c_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = FN_LOAD;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   always #1 clock = ~clock;

   coo_to_csr_converter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------------
   // Matrix shadow: histogram, row pointers, staging and CSR storage
   // ---------------------------------------------------------------------
   int                     hist_count [ROW_MAX];
   int                     row_ptr    [ROW_MAX+1];
   int                     row_cursor [ROW_MAX];
   logic [9:0]             stage_row  [FILL_MAX];
   logic [9:0]             stage_col  [FILL_MAX];
   logic [C2C_VALUE_W-1:0] stage_val  [FILL_MAX];
   logic [9:0]             csr_col    [FILL_MAX];
   logic [C2C_VALUE_W-1:0] csr_val    [FILL_MAX];
   int                     entry_count;
   bit                     matrix_done;
   bit                     capacity_hit;

   c2c_request_type request_queue [$];
   rsp_type         expected_responses [$];

   int failures;
   int n_loads, n_reads, n_matrices, n_checked;
   int n_ok, n_overflow, n_range, n_badread;

   function automatic void clear_matrix();
      for (int r = 0; r < ROW_MAX; r++) hist_count[r] = 0;
      for (int r = 0; r <= ROW_MAX; r++) row_ptr[r] = 0;
      entry_count  = 0;
      matrix_done  = 1'b0;
      capacity_hit = 1'b0;
   endfunction

   // prefix sum, then stable scatter in arrival order
   function automatic void build_csr();
      int dest;
      row_ptr[0] = 0;
      for (int r = 0; r < ROW_MAX; r++) row_ptr[r+1] = row_ptr[r] + hist_count[r];
      for (int r = 0; r < ROW_MAX; r++) row_cursor[r] = row_ptr[r];
      for (int i = 0; i < entry_count; i++) begin
         dest = row_cursor[stage_row[i]];
         csr_col[dest] = stage_col[i];
         csr_val[dest] = stage_val[i];
         row_cursor[stage_row[i]] = dest + 1;
      end
      matrix_done = 1'b1;
   endfunction

   // Updates the shadow for one accepted request; returns 1 when a response is due.
   function automatic bit compute_response(input c2c_request_type rq, output rsp_type rs);
      logic [STATUS_W-1:0] code;
      rs   = '0;
      code = ST_OK;
      case (rq.func)
         FN_LOAD: begin
            // first load after a finished matrix starts over
            if (matrix_done) clear_matrix();
            if (rq.row < 1 || rq.row > ROW_MAX || rq.col < 1 || rq.col > ROW_MAX) begin
               code = ST_RANGE;
            end else if (entry_count >= FILL_MAX) begin
               code = ST_OVERFLOW;
               capacity_hit = 1'b1;
            end else begin
               stage_row[entry_count] = 10'(rq.row - 11'd1);
               stage_col[entry_count] = 10'(rq.col - 11'd1);
               stage_val[entry_count] = rq.val;
               hist_count[rq.row - 11'd1]++;
               entry_count++;
            end
            if (rq.fin) begin
               build_csr();
               if (code == ST_OK && capacity_hit) code = ST_OVERFLOW;
               rs.entry_total = 13'(entry_count);
               rs.status      = code;
               return 1'b1;
            end
            rs.status = code;
            return code != ST_OK;
         end
         FN_READ_PTR: begin
            if (!matrix_done || rq.idx > ROW_MAX) rs.status = ST_BADREAD;
            else rs.row_start = 13'(row_ptr[rq.idx]);
            return 1'b1;
         end
         FN_READ_ENTRY: begin
            if (!matrix_done || rq.idx >= entry_count) begin
               rs.status = ST_BADREAD;
            end else begin
               rs.out_column = csr_col[rq.idx];
               rs.out_value  = csr_val[rq.idx];
            end
            return 1'b1;
         end
         default: begin
            rs.status = ST_BADREAD;
            return 1'b1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Idle gaps: mostly short, a few long, with calm stretches of none.
   // side 0 = request sender, side 1 = response receiver
   // ---------------------------------------------------------------------
   int unsigned calm_left [2];

   function automatic int unsigned next_gap(input int side);
      int unsigned pick;
      if (calm_left[side] != 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 199) == 0) calm_left[side] = $urandom_range(50, 300);
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 16);
      return $urandom_range(30, 150);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: presents queued requests, idles between them
   // ---------------------------------------------------------------------
   int unsigned req_gap;

   always @(posedge clock) begin : drive_requests
      c2c_request_type nxt;
      req_type         pkt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap != 0 || request_queue.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap != 0) req_gap <= req_gap - 1;
         end else begin
            nxt               = request_queue.pop_front();
            pkt               = '0;
            pkt.row_number    = nxt.row;
            pkt.column_number = nxt.col;
            pkt.entry_value   = nxt.val;
            pkt.read_index    = nxt.idx;
            req_tvalid        <= 1'b1;
            req_tdata         <= pkt;
            req_tuser         <= nxt.func;
            req_tlast         <= nxt.fin;
            req_gap           <= next_gap(0);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random backpressure
   // ---------------------------------------------------------------------
   int unsigned rsp_stall;

   always @(posedge clock) begin : drive_ready
      int unsigned gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         gap = next_gap(1);
         rsp_tready <= (gap == 0);
         rsp_stall  <= (gap == 0) ? 0 : gap - 1;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         // occasional stall even with nothing pending, so the first response can wait too
         rsp_tready <= ($urandom_range(0, 7) != 0);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted response
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      req_type         seen;
      c2c_request_type rq;
      rsp_type         want;
      rsp_type         got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen    = req_tdata;
            rq.func = req_tuser;
            rq.row  = seen.row_number;
            rq.col  = seen.column_number;
            rq.val  = seen.entry_value;
            rq.fin  = req_tlast;
            rq.idx  = seen.read_index;
            if (rq.func == FN_LOAD) n_loads++;
            else n_reads++;
            if (rq.func == FN_LOAD && rq.fin) n_matrices++;
            if (compute_response(rq, want)) expected_responses.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_responses.size() == 0) begin
               $error("response with none expected: %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_responses.pop_front();
               n_checked++;
               case (want.status)
                  ST_OK:       n_ok++;
                  ST_OVERFLOW: n_overflow++;
                  ST_RANGE:    n_range++;
                  default:     n_badread++;
               endcase
               if (got.entry_total !== want.entry_total) begin
                  $error("entry_total: expected %0d, actual %0d",
                         want.entry_total, got.entry_total);
                  failures++;
               end
               if (got.row_start !== want.row_start) begin
                  $error("row_start: expected %0d, actual %0d", want.row_start, got.row_start);
                  failures++;
               end
               if (got.out_column !== want.out_column) begin
                  $error("out_column: expected %0d, actual %0d",
                         want.out_column, got.out_column);
                  failures++;
               end
               if (got.out_value !== want.out_value) begin
                  $error("out_value: expected %h, actual %h", want.out_value, got.out_value);
                  failures++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  failures++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   task automatic push_load(input int row, input int col, input logic [31:0] val,
                            input bit fin);
      c2c_request_type rq;
      rq.func = FN_LOAD;
      rq.row  = 11'(row);
      rq.col  = 11'(col);
      rq.val  = val;
      rq.fin  = fin;
      rq.idx  = 13'($urandom_range(0, 8191));  // don't care on a load
      request_queue.push_back(rq);
   endtask

   task automatic push_read(input logic [FUNC_W-1:0] func, input int idx, input bit fin);
      c2c_request_type rq;
      rq.func = func;
      rq.row  = 11'($urandom_range(0, 2047));
      rq.col  = 11'($urandom_range(0, 2047));
      rq.val  = $urandom;
      rq.fin  = fin;
      rq.idx  = 13'(idx);
      request_queue.push_back(rq);
   endtask

   function automatic logic [FUNC_W-1:0] any_read_func();
      int unsigned pick;
      pick = $urandom_range(0, 2);
      return (pick == 0) ? FN_READ_PTR : (pick == 1) ? FN_READ_ENTRY : FN_UNUSED;
   endfunction

   // Reads after a conversion; good = entries the matrix should hold,
   // probe = a one-based row known to be populated.
   task automatic gen_reads(input int n, input int good, input int probe);
      int unsigned sel;
      int unsigned how;
      int          idx;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         how = $urandom_range(0, 9);
         if (sel < 45) begin
            if (how < 5) idx = probe - 1 + $urandom_range(0, 1);
            else if (how < 8) idx = $urandom_range(0, ROW_MAX);
            else if (how < 9) idx = $urandom_range(0, 1) ? ROW_MAX : 0;
            else idx = $urandom_range(0, 8191);
            push_read(FN_READ_PTR, idx, $urandom_range(0, 7) == 0);
         end else if (sel < 96) begin
            if (how < 8) idx = (good > 0) ? $urandom_range(0, good - 1) : 0;
            else if (how < 9) idx = good;
            else idx = $urandom_range(0, 8191);
            push_read(FN_READ_ENTRY, idx, $urandom_range(0, 7) == 0);
         end else begin
            push_read(FN_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 1));
         end
      end
   endtask

   // One matrix: loads ending in a final load, then reads. hot keeps rows in a
   // narrow window so rows collect several entries each.
   task automatic gen_matrix(input int load_count, input int read_count, input bit hot);
      int good, base, span, row, col, probe;
      good  = 0;
      probe = 1;
      base  = $urandom_range(1, ROW_MAX);
      span  = hot ? $urandom_range(0, 15) : ROW_MAX;
      for (int k = 0; k < load_count; k++) begin
         // stray read while the matrix is still open
         if ($urandom_range(0, 32) == 0)
            push_read(any_read_func(), $urandom_range(0, 8191), $urandom_range(0, 1));
         if ($urandom_range(0, 19) == 0) begin
            row = $urandom_range(0, 2047);
            col = $urandom_range(0, 2047);
         end else begin
            row = base + $urandom_range(0, span);
            if (row > ROW_MAX) row = row - ROW_MAX;
            case ($urandom_range(0, 15))
               0:       col = 1;
               1:       col = ROW_MAX;
               default: col = $urandom_range(1, ROW_MAX);
            endcase
         end
         if (row >= 1 && row <= ROW_MAX && col >= 1 && col <= ROW_MAX) begin
            if (good < FILL_MAX) good++;
            if ($urandom_range(0, 2) == 0 || good == 1) probe = row;
         end
         push_load(row, col, $urandom, k == load_count - 1);
      end
      gen_reads(read_count, good, probe);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int random_items;
      int queued_prior;
      bit overflow_done;
      clear_matrix();
      reset         = 1'b1;
      random_items  = 0;
      overflow_done = 1'b0;

      // directed: reads before any matrix, coordinate extremes, out-of-range
      // drops, two entries in one row, a read while loading
      push_read(FN_READ_PTR, 0, 1'b0);
      push_read(FN_READ_ENTRY, 0, 1'b0);
      push_read(FN_UNUSED, 0, 1'b1);
      push_load(1, 1, 32'h0000_0000, 1'b0);
      push_load(ROW_MAX, ROW_MAX, 32'hFFFF_FFFF, 1'b0);
      push_load(0, 5, 32'h1234_5678, 1'b0);
      push_load(5, 0, 32'h8765_4321, 1'b0);
      push_load(ROW_MAX + 1, 1, 32'hDEAD_BEEF, 1'b0);
      push_load(2047, 2047, 32'hCAFE_F00D, 1'b0);
      push_load(1, ROW_MAX, 32'hA5A5_5A5A, 1'b0);
      push_read(FN_READ_PTR, 1, 1'b0);
      push_load(512, 3, 32'h0F0F_F0F0, 1'b1);
      // reads of the finished matrix, both index extremes
      push_read(FN_READ_PTR, 0, 1'b0);
      push_read(FN_READ_PTR, 1, 1'b1);
      push_read(FN_READ_PTR, ROW_MAX, 1'b0);
      push_read(FN_READ_PTR, ROW_MAX + 1, 1'b0);
      push_read(FN_READ_ENTRY, 0, 1'b0);
      push_read(FN_READ_ENTRY, 1, 1'b0);
      push_read(FN_READ_ENTRY, 3, 1'b0);
      push_read(FN_READ_ENTRY, 4, 1'b0);
      push_read(FN_READ_ENTRY, 8191, 1'b0);
      // new matrix: a load clears, reads are rejected until the final load,
      // and a dropped final load still converts
      push_load(3, 3, 32'h0000_0001, 1'b0);
      push_read(FN_READ_PTR, 1, 1'b0);
      push_load(ROW_MAX + 7, 9, 32'h0000_0002, 1'b1);
      push_read(FN_READ_ENTRY, 0, 1'b0);

      // random matrices, plus one run that fills the staging RAM and overflows
      while (random_items < 2000) begin
         if (!overflow_done && random_items > 1000) begin
            overflow_done = 1'b1;
            for (int k = 0; k < FILL_MAX; k++)
               push_load($urandom_range(1, ROW_MAX), $urandom_range(1, ROW_MAX), $urandom, 1'b0);
            push_load(7, 7, $urandom, 1'b0);            // dropped, capacity
            push_load(ROW_MAX, 1, $urandom, 1'b0);      // dropped, capacity
            push_load(0, ROW_MAX + 1, $urandom, 1'b0);  // dropped, range
            push_load(2, 2, $urandom, 1'b1);            // final, reports overflow
            push_read(FN_READ_ENTRY, FILL_MAX - 1, 1'b0);
            push_read(FN_READ_ENTRY, FILL_MAX, 1'b0);
            push_read(FN_READ_PTR, ROW_MAX, 1'b0);
            gen_reads(30, FILL_MAX, $urandom_range(1, ROW_MAX));
         end
         queued_prior = request_queue.size();
         gen_matrix(($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 30),
                    $urandom_range(1, 30), $urandom_range(0, 2) != 0);
         random_items += request_queue.size() - queued_prior;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, every response back, then room for a late extra
      while (request_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d loads and %0d reads over %0d matrices; checked %0d responses.",
               n_loads, n_reads, n_matrices, n_checked);
      $display("Responses by status: %0d ok, %0d overflow, %0d out of range, %0d bad read.",
               n_ok, n_overflow, n_range, n_badread);
      if (failures == 0 && expected_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
